// ===== rtl/nts_pkg.sv =====
// nts_pkg: shared types and constants of the nearest timestamp matcher
`timescale 1ns / 1ps

package nts_pkg;

   localparam int STAMP_W  = 63;
   localparam int EXPO_W   = 32;
   localparam int THRESH_W = 32;
   localparam int STATUS_W = 2;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 32'd200000000;
   localparam logic [STAMP_W-1:0]  STAMP_MAX    = {STAMP_W{1'b1}};

   typedef enum logic [STATUS_W-1:0] {
      ST_MATCHED   = 2'd0,
      ST_NO_STAMPS = 2'd1,
      ST_BEYOND    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIFF,
      S_WALK,
      S_REPLY
   } state_type;

   // running best of the search as it travels down the cell row
   typedef struct packed {
      logic               found;
      logic [STAMP_W-1:0] diff;
      logic [STAMP_W-1:0] stamp;
   } probe_type;

   function automatic logic [STAMP_W-1:0] abs_diff(input logic [STAMP_W-1:0] a,
                                                   input logic [STAMP_W-1:0] b);
      logic [STAMP_W-1:0] res;
      if (a >= b) begin
         res = a - b;
      end else begin
         res = b - a;
      end
      return res;
   endfunction

endpackage

// ===== rtl/nts_if.sv =====
// nts_if: handshake channels of the nearest timestamp matcher
`timescale 1ns / 1ps

interface nts_req_if;
   logic                        valid;
   logic                        ready;
   logic                        kind;
   logic [nts_pkg::STAMP_W-1:0] stamp_ns;
   logic [nts_pkg::EXPO_W-1:0]  exposure_ns;

   modport source (output valid, kind, stamp_ns, exposure_ns, input ready);
   modport sink   (input valid, kind, stamp_ns, exposure_ns, output ready);
endinterface

interface nts_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [nts_pkg::STATUS_W-1:0] status;
   logic [nts_pkg::STAMP_W-1:0]  corrected_stamp_ns;
   logic [nts_pkg::STAMP_W-1:0]  match_diff_ns;

   modport source (output valid, status, corrected_stamp_ns, match_diff_ns, input ready);
   modport sink   (input valid, status, corrected_stamp_ns, match_diff_ns, output ready);
endinterface

interface nts_csr_if;
   logic                         valid;
   logic                         ready;
   logic [nts_pkg::THRESH_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/nts_cell.sv =====
// nts_cell: one storage cell of the stamp row with its distance and search step
`timescale 1ns / 1ps

module nts_cell #(
   parameter int CELL_INDEX = 0,
   parameter int IDX_W      = 6
) (
   input  logic                        clock,
   input  logic                        reset,
   // stamp shift from the newer neighbor
   input  logic                        shift_en,
   input  logic [nts_pkg::STAMP_W-1:0] shift_stamp,
   input  logic                        shift_valid,
   output logic [nts_pkg::STAMP_W-1:0] stamp_out,
   output logic                        valid_out,
   // distance load
   input  logic                        diff_en,
   input  logic [nts_pkg::STAMP_W-1:0] img_stamp,
   // search probe from the newer neighbor, passed on to the older one
   input  logic                        probe_in_valid,
   input  nts_pkg::probe_type          probe_in,
   input  logic [IDX_W-1:0]            probe_in_idx,
   output logic                        probe_out_valid,
   output nts_pkg::probe_type          probe_out,
   output logic [IDX_W-1:0]            probe_out_idx,
   // drop of the matched stamp and all older ones
   input  logic                        cut_en,
   input  logic [IDX_W-1:0]            cut_idx
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

   logic [nts_pkg::STAMP_W-1:0] stamp_ff;
   logic                        valid_ff;
   logic [nts_pkg::STAMP_W-1:0] diff_ff;
   logic                        pvalid_ff;
   nts_pkg::probe_type          probe_ff;
   logic [IDX_W-1:0]            pidx_ff;
   nts_pkg::probe_type          probe_in_sel;
   logic                        take;

   // equal distance: the older cell (higher index) takes over
   assign take = probe_in_valid && valid_ff &&
                 (!probe_in.found || (diff_ff <= probe_in.diff));

   always_comb begin
      probe_in_sel = probe_in;
      if (take) begin
         probe_in_sel.found = 1'b1;
         probe_in_sel.diff  = diff_ff;
         probe_in_sel.stamp = stamp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         pvalid_ff <= 1'b0;
      end else begin
         pvalid_ff <= probe_in_valid;
         if (shift_en) begin
            valid_ff <= shift_valid;
         end else if (cut_en && (MY_IDX >= cut_idx)) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         stamp_ff <= shift_stamp;
      end
      if (diff_en) begin
         diff_ff <= nts_pkg::abs_diff(img_stamp, stamp_ff);
      end
      probe_ff <= probe_in_sel;
      pidx_ff  <= take ? MY_IDX : probe_in_idx;
   end

   assign stamp_out       = stamp_ff;
   assign valid_out       = valid_ff;
   assign probe_out_valid = pvalid_ff;
   assign probe_out       = probe_ff;
   assign probe_out_idx   = pidx_ff;

endmodule

// ===== rtl/nearest_timestamp_matcher.sv =====
// nearest_timestamp_matcher: top level, cell row of trigger stamps and match sequencer
`timescale 1ns / 1ps

// Stores trigger timestamps in a row of FIFO_DEPTH cells, newest in cell 0 and
// oldest at the far end; a trigger transfer shifts the row by one cell,
// dropping the oldest stamp when the row is full, and the next item is taken
// in the following cycle. An image transfer holds the input until its result
// has gone to the output register: first every cell computes its distance to
// the image stamp in parallel, then the search probe walks the row one cell per
// cycle carrying the best distance so far (equal distance: the older stamp
// wins), then the result is captured and the reply cycle loads it. The
// reply cycle waits while an earlier result still sits unread in the output
// register. Each image gives one result: status matched with the matched stamp
// plus half the exposure (floored, saturating at 2^63-1), no stored stamps
// (other fields zero), or beyond threshold (corrected stamp zero). On a match
// or a threshold miss the nearest stamp and every older one are removed.
// max_match_diff_ns is to be written through the csr channel only while the
// block is idle; the block itself does not enforce this. It resets to 200000000.
module nearest_timestamp_matcher #(
   parameter int FIFO_DEPTH = 40
) (
   input  logic      clock,
   input  logic      reset,
   nts_req_if.sink   req_ch,
   nts_rsp_if.source rsp_ch,
   nts_csr_if.sink   csr_ch
);

   localparam int IDX_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

   nts_pkg::state_type                state_ff, state_in;
   logic [nts_pkg::THRESH_W-1:0]      thresh_ff;
   logic [nts_pkg::STAMP_W-1:0]       img_ff;
   logic [nts_pkg::EXPO_W-1:0]        expo_ff;
   logic                              launch_ff;

   // captured end of the search walk
   nts_pkg::probe_type                cap_ff;
   logic [IDX_W-1:0]                  cap_idx_ff;

   // output register
   logic                              rsp_valid_ff;
   nts_pkg::status_type               rsp_status_ff, rsp_status_in;
   logic [nts_pkg::STAMP_W-1:0]       rsp_corr_ff, rsp_corr_in;
   logic [nts_pkg::STAMP_W-1:0]       rsp_diff_ff, rsp_diff_in;

   logic                              req_xfer;
   logic                              trig_xfer;
   logic                              reply_go;
   logic                              cut_en;
   logic [nts_pkg::STAMP_W:0]         sum;

   // row wiring: element k feeds cell k, element k+1 comes out of it
   logic [nts_pkg::STAMP_W-1:0]       row_stamp [FIFO_DEPTH+1];
   logic                              row_valid [FIFO_DEPTH+1];
   logic                              row_pvalid [FIFO_DEPTH+1];
   nts_pkg::probe_type                row_probe [FIFO_DEPTH+1];
   logic [IDX_W-1:0]                  row_pidx [FIFO_DEPTH+1];

   assign req_ch.ready = (state_ff == nts_pkg::S_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign trig_xfer    = req_xfer && !req_ch.kind;

   // the new stamp enters at cell 0, the row shifts toward the oldest end
   assign row_stamp[0]  = req_ch.stamp_ns;
   assign row_valid[0]  = 1'b1;

   // fresh probe: nothing found yet
   assign row_pvalid[0] = launch_ff;
   assign row_probe[0]  = '0;
   assign row_pidx[0]   = '0;

   // reply goes out once the output register is free
   assign reply_go = (state_ff == nts_pkg::S_REPLY) && (!rsp_valid_ff || rsp_ch.ready);
   // nothing to remove when the row was empty
   assign cut_en   = reply_go && cap_ff.found;

   generate
      for (genvar k = 0; k < FIFO_DEPTH; k++) begin : g_cell
         nts_cell #(
            .CELL_INDEX (k),
            .IDX_W      (IDX_W)
         ) u_cell (
            .clock           (clock),
            .reset           (reset),
            .shift_en        (trig_xfer),
            .shift_stamp     (row_stamp[k]),
            .shift_valid     (row_valid[k]),
            .stamp_out       (row_stamp[k+1]),
            .valid_out       (row_valid[k+1]),
            .diff_en         (state_ff == nts_pkg::S_DIFF),
            .img_stamp       (img_ff),
            .probe_in_valid  (row_pvalid[k]),
            .probe_in        (row_probe[k]),
            .probe_in_idx    (row_pidx[k]),
            .probe_out_valid (row_pvalid[k+1]),
            .probe_out       (row_probe[k+1]),
            .probe_out_idx   (row_pidx[k+1]),
            .cut_en          (cut_en),
            .cut_idx         (cap_idx_ff)
         );
      end
   endgenerate

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= nts_pkg::S_IDLE;
         launch_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         launch_ff <= (state_ff == nts_pkg::S_DIFF);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         nts_pkg::S_IDLE: begin
            if (req_xfer && req_ch.kind) begin
               state_in = nts_pkg::S_DIFF;
            end
         end
         nts_pkg::S_DIFF: begin
            state_in = nts_pkg::S_WALK;
         end
         nts_pkg::S_WALK: begin
            // probe leaving the oldest cell ends the walk
            if (row_pvalid[FIFO_DEPTH]) begin
               state_in = nts_pkg::S_REPLY;
            end
         end
         nts_pkg::S_REPLY: begin
            if (reply_go) begin
               state_in = nts_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = nts_pkg::S_IDLE;
         end
      endcase
   end

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= nts_pkg::THRESH_RESET;
      end else if (csr_ch.valid && csr_ch.ready) begin
         thresh_ff <= csr_ch.data;
      end
   end

   // image item and walk result
   always_ff @(posedge clock) begin
      if (req_xfer && req_ch.kind) begin
         img_ff  <= req_ch.stamp_ns;
         expo_ff <= req_ch.exposure_ns;
      end
      if ((state_ff == nts_pkg::S_WALK) && row_pvalid[FIFO_DEPTH]) begin
         cap_ff     <= row_probe[FIFO_DEPTH];
         cap_idx_ff <= row_pidx[FIFO_DEPTH];
      end
   end

   // result fields: threshold compare and saturating sum side by side
   assign sum = {1'b0, cap_ff.stamp} +
                {{(nts_pkg::STAMP_W + 1 - (nts_pkg::EXPO_W - 1)){1'b0}},
                 expo_ff[nts_pkg::EXPO_W-1:1]};

   always_comb begin
      rsp_status_in = nts_pkg::ST_MATCHED;
      rsp_corr_in   = '0;
      rsp_diff_in   = cap_ff.diff;
      if (!cap_ff.found) begin
         rsp_status_in = nts_pkg::ST_NO_STAMPS;
         rsp_diff_in   = '0;
      end else if (cap_ff.diff >
                   {{(nts_pkg::STAMP_W - nts_pkg::THRESH_W){1'b0}}, thresh_ff}) begin
         rsp_status_in = nts_pkg::ST_BEYOND;
      end else if (sum[nts_pkg::STAMP_W]) begin
         rsp_corr_in = nts_pkg::STAMP_MAX;
      end else begin
         rsp_corr_in = sum[nts_pkg::STAMP_W-1:0];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (reply_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reply_go) begin
         rsp_status_ff <= rsp_status_in;
         rsp_corr_ff   <= rsp_corr_in;
         rsp_diff_ff   <= rsp_diff_in;
      end
   end

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.status             = rsp_status_ff;
   assign rsp_ch.corrected_stamp_ns = rsp_corr_ff;
   assign rsp_ch.match_diff_ns      = rsp_diff_ff;

endmodule

// ===== rtl/nts_checker.sv =====
// nts_checker: port-level assertions of the nearest timestamp matcher and its bind
`timescale 1ns / 1ps

module nts_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_kind,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [nts_pkg::STATUS_W-1:0] rsp_status,
   input logic [nts_pkg::STAMP_W-1:0]  rsp_corrected,
   input logic [nts_pkg::STAMP_W-1:0]  rsp_diff
);

   // a result waiting for its transfer keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_status) && $stable(rsp_corrected) && $stable(rsp_diff))
      else $error("result payload changed while stalled");

   // an image transfer starts a search, no item is taken right after it
   a_image_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind |=> !req_ready)
      else $error("item taken during image search");

   // a trigger transfer is stored at once, the next item may follow
   a_trigger_fast: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_kind |=> req_ready)
      else $error("trigger stalled the input");

   // an empty row gives zero fields, a threshold miss gives no corrected stamp
   a_status_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_status == nts_pkg::ST_MATCHED) ||
         ((rsp_status == nts_pkg::ST_NO_STAMPS) && (rsp_corrected == '0) && (rsp_diff == '0)) ||
         ((rsp_status == nts_pkg::ST_BEYOND) && (rsp_corrected == '0)))
      else $error("result fields disagree with status");

endmodule

bind nearest_timestamp_matcher nts_checker u_nts_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .req_kind      (req_ch.kind),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_status    (rsp_ch.status),
   .rsp_corrected (rsp_ch.corrected_stamp_ns),
   .rsp_diff      (rsp_ch.match_diff_ns)
);
